@@ src/trial_division_primality_test_defines.svh @@
// ----------------------------------------------------------------------------
// Trial division primality test: assertion macros
// Shared forms for the concurrent assertions of the block, clocked on clk
// and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tdpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Trial division primality test: package
// Shared widths and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int NUMBER_WIDTH = 32;
    localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(NUMBER_WIDTH - 1);

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic d_advance;
    } tdpt_cmd_t;

    typedef struct packed {
        logic not_above_one;
        logic is_two;
        logic is_even;
        logic div_last;
        logic d_beyond;
        logic rem_zero;
    } tdpt_status_t;

endpackage

@@ src/tdpt_datapath.sv @@
// ----------------------------------------------------------------------------
// Trial division primality test: datapath
// Holds the number and the trial divisor, and a restoring divider that
// produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdpt_datapath
    import tdpt_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [NUMBER_WIDTH-1:0] number_in,
    input  tdpt_cmd_t                      cmd,
    output tdpt_status_t                   status
);

    logic [NUMBER_WIDTH-1:0] n_reg;
    logic [NUMBER_WIDTH-1:0] d_reg;
    logic [NUMBER_WIDTH-1:0] dvd_reg;
    logic [NUMBER_WIDTH-1:0] rem_reg;
    logic [NUMBER_WIDTH-1:0] quot_reg;
    logic [CNT_WIDTH-1:0]    cnt_reg;

    logic [NUMBER_WIDTH-1:0] rem_shift;
    logic                    q_bit;
    logic [NUMBER_WIDTH-1:0] rem_next;

    always_comb
    begin
        rem_shift = {rem_reg[NUMBER_WIDTH-2:0], dvd_reg[NUMBER_WIDTH-1]};
        q_bit     = (rem_shift >= d_reg);
        rem_next  = q_bit ? (rem_shift - d_reg) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= NUMBER_WIDTH'(unsigned'(number_in));
            d_reg <= NUMBER_WIDTH'(3);
        end
        else if (cmd.d_advance)
        begin
            d_reg <= d_reg + NUMBER_WIDTH'(2);
        end

        if (cmd.div_init)
        begin
            dvd_reg  <= n_reg;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg  <= {dvd_reg[NUMBER_WIDTH-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[NUMBER_WIDTH-2:0], q_bit};
        end
    end

    always_comb
    begin
        status.not_above_one = n_reg[NUMBER_WIDTH-1] || (n_reg[NUMBER_WIDTH-1:1] == '0);
        status.is_two        = (n_reg == NUMBER_WIDTH'(2));
        status.is_even       = ~n_reg[0];
        status.div_last      = (cnt_reg == CNT_LAST);
        status.d_beyond      = (d_reg > quot_reg);
        status.rem_zero      = (rem_reg == '0);
    end

endmodule

@@ src/tdpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Trial division primality test: controller
// Sequences the special cases, one division per trial divisor, and the
// result strobe.
// ----------------------------------------------------------------------------
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  tdpt_status_t status,
    output tdpt_cmd_t    cmd,
    output logic         busy,
    output logic         done,
    output logic         prime_flag
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DIVIDE,
        ST_EVALUATE
    } state_t;

    state_t state_reg;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_CLASSIFY:
            begin
                cmd.div_init = 1'b1;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_EVALUATE:
            begin
                cmd.div_init  = 1'b1;
                cmd.d_advance = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done       <= 1'b0;
            prime_flag <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_CLASSIFY;
                    end
                end
                ST_CLASSIFY:
                begin
                    if (status.not_above_one || (status.is_even && !status.is_two))
                    begin
                        done       <= 1'b1;
                        prime_flag <= 1'b0;
                        state_reg  <= ST_IDLE;
                    end
                    else if (status.is_two)
                    begin
                        done       <= 1'b1;
                        prime_flag <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (status.div_last)
                    begin
                        state_reg <= ST_EVALUATE;
                    end
                end
                ST_EVALUATE:
                begin
                    if (status.d_beyond)
                    begin
                        done       <= 1'b1;
                        prime_flag <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                    else if (status.rem_zero)
                    begin
                        done       <= 1'b1;
                        prime_flag <= 1'b0;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/trial_division_primality_test.sv @@
// ----------------------------------------------------------------------------
// Trial division primality test: top level
// Decides whether a signed integer is prime by dividing it by the odd
// divisors 3, 5, 7, ... while the divisor does not exceed the quotient.
//
// Channel   Handshake           Payload
// input     start, busy         number_in
// result    done (one cycle)    prime_flag
//
// Values of 1 or less, two and other even values finish in the classify
// state without a division. Each odd trial divisor costs one full pass of
// the bit-serial restoring divider, followed by the evaluate state.
// Reset is asynchronous and returns the block to idle with no result pending.
// The receiver cannot stall; done is high for exactly one cycle per transaction.
// ----------------------------------------------------------------------------
`include "trial_division_primality_test_defines.svh"

module trial_division_primality_test
    import tdpt_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [NUMBER_WIDTH-1:0] number_in,
    output logic                           done,
    output logic                           prime_flag
);

    tdpt_cmd_t    cmd;
    tdpt_status_t status;

    tdpt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done),
        .prime_flag (prime_flag)
    );

    tdpt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .number_in (number_in),
        .cmd       (cmd),
        .status    (status)
    );

    `TDPT_ASSERT_SAME(a_done_idle, done, !busy, "Result strobe while still busy.")
    `TDPT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "Accepted transaction did not start.")
    `TDPT_ASSERT_SAME(a_finish_done, $fell(busy), done, "Block went idle without a result.")
    `TDPT_ASSERT_NEXT(a_single_strobe, done, !done, "Result strobe lasted more than one cycle.")

endmodule
